// ===== src/sukt_pkg.sv =====
package sukt_pkg;

  localparam int IdW    = 32;
  localparam int RefW   = 16;
  localparam int GradeW = 10;
  localparam int FuncW  = 3;
  localparam int StartW = 7;
  localparam int PosW   = 6;
  localparam int CountW = 7;
  localparam int StatW  = 2;

  localparam logic [GradeW-1:0] GradeMax = 10'd1000;

  localparam logic [FuncW-1:0] FUNC_INSERT    = 3'd0;
  localparam logic [FuncW-1:0] FUNC_DELETE    = 3'd1;
  localparam logic [FuncW-1:0] FUNC_FIND_ID   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_FIND_LAST = 3'd3;
  localparam logic [FuncW-1:0] FUNC_FIND_MAJ  = 3'd4;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_DUP      = 2'd1;
  localparam logic [StatW-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [StatW-1:0] ST_FULL     = 2'd3;

  // Operation classes reported by the datapath to the controller.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_OTHER  = 2'd3;

  typedef struct packed {
    logic        [FuncW-1:0]  func;
    logic        [StartW-1:0] start_position;
    logic signed [IdW-1:0]    id_key;
    logic        [RefW-1:0]   first_name_ref;
    logic        [RefW-1:0]   last_name_ref;
    logic        [RefW-1:0]   major_ref;
    logic        [GradeW-1:0] gpa_hundredths;
  } sukt_req_t;

  typedef struct packed {
    logic        [StatW-1:0]  status;
    logic        [PosW-1:0]   found_position;
    logic signed [IdW-1:0]    out_id;
    logic        [RefW-1:0]   out_first_name_ref;
    logic        [RefW-1:0]   out_last_name_ref;
    logic        [RefW-1:0]   out_major_ref;
    logic        [GradeW-1:0] out_gpa_hundredths;
    logic        [CountW-1:0] entry_count_out;
  } sukt_rsp_t;

  typedef struct packed {
    logic        [IdW-1:0]    id;
    logic        [RefW-1:0]   first;
    logic        [RefW-1:0]   last;
    logic        [RefW-1:0]   major;
    logic        [GradeW-1:0] grade;
  } sukt_rec_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture request and evaluate all cells
    logic shift_in; // open a gap and write the new record
    logic shift_out;// close the gap of the removed record
    logic respond;  // drive the result register
  } sukt_cmd_t;

endpackage

// ===== src/sukt_datapath.sv =====
module sukt_datapath #(
  parameter int DEPTH = 64,
  parameter int IW    = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sukt_pkg::sukt_req_t req,
  input  sukt_pkg::sukt_cmd_t cmd,
  output logic [1:0]          op_sel,
  output sukt_pkg::sukt_rsp_t rsp
);
  import sukt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (IW > StartW) ? IW : StartW;

  // Register cells holding the sorted records.
  sukt_rec_t  cell_r [DEPTH];
  sukt_rec_t  cell_nxt [DEPTH];
  logic [IW-1:0] count_r, count_nxt;
  sukt_req_t  req_r;
  sukt_rsp_t  rsp_r, rsp_nxt;

  // Per-cell compare results, registered on load.
  logic [DEPTH-1:0] id_eq, ref_eq, less, used, from_start;
  logic [DEPTH-1:0] id_eq_r, find_hit_r, less_r;
  logic [IW-1:0]    ins_pos;
  logic [AW-1:0]    dup_idx, find_idx;
  logic             dup_any, find_any;
  logic [IW-1:0]    ins_pos_r;
  logic [AW-1:0]    dup_idx_r, find_idx_r;
  logic             dup_r, found_r;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      used[i]       = IW'(i) < count_r;
      from_start[i] = (CW'(i) >= CW'(req.start_position)) && used[i];
      id_eq[i]      = (cell_r[i].id == req.id_key) && used[i];
      ref_eq[i]     = ((req.func == FUNC_FIND_ID)   && cell_r[i].id == req.id_key) ||
                      ((req.func == FUNC_FIND_LAST) && cell_r[i].last == req.last_name_ref) ||
                      ((req.func == FUNC_FIND_MAJ)  && cell_r[i].major == req.major_ref);
      less[i]       = used[i] &&
                      ((cell_r[i].id ^ 32'h8000_0000) < (req.id_key ^ 32'h8000_0000));
    end
  end

  // Priority encode of the registered hit vectors. The insert position is
  // the first cell whose id is not below the key.
  always_comb begin
    dup_any  = 1'b0;
    find_any = 1'b0;
    dup_idx  = '0;
    find_idx = '0;
    ins_pos  = IW'(DEPTH);
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (id_eq_r[i]) begin
        dup_any = 1'b1;
        dup_idx = AW'(i);
      end
      if (find_hit_r[i]) begin
        find_any = 1'b1;
        find_idx = AW'(i);
      end
      if (!less_r[i]) ins_pos = IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= req;
      id_eq_r    <= id_eq;
      find_hit_r <= ref_eq & from_start;
      less_r     <= less;
    end
  end

  always_ff @(posedge clk) begin
    dup_r     <= dup_any;
    found_r   <= find_any;
    dup_idx_r <= dup_idx;
    find_idx_r <= find_idx;
    ins_pos_r <= ins_pos;
  end

  // Operation class for the controller.
  always_comb begin
    unique case (req_r.func)
      FUNC_INSERT: op_sel = OP_INSERT;
      FUNC_DELETE: op_sel = OP_DELETE;
      FUNC_FIND_ID, FUNC_FIND_LAST, FUNC_FIND_MAJ: op_sel = OP_FIND;
      default: op_sel = OP_OTHER;
    endcase
  end

  // Cell shifts for insert and delete.
  sukt_rec_t new_rec;
  logic      do_ins, do_del;
  always_comb begin
    new_rec.id    = req_r.id_key;
    new_rec.first = req_r.first_name_ref;
    new_rec.last  = req_r.last_name_ref;
    new_rec.major = req_r.major_ref;
    new_rec.grade = (req_r.gpa_hundredths > GradeMax) ? GradeMax : req_r.gpa_hundredths;
    do_ins = cmd.shift_in && !dup_r && (count_r < IW'(DEPTH));
    do_del = cmd.shift_out && dup_r;
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_ins) begin
        if (IW'(i) == ins_pos_r) cell_nxt[i] = new_rec;
        else if (IW'(i) > ins_pos_r && i > 0) cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
      end else if (do_del) begin
        if (IW'(i) >= IW'(dup_idx_r) && i < DEPTH - 1) cell_nxt[i] = cell_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
    if (do_ins) count_nxt = count_r + 1'b1;
    else if (do_del) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) cell_r[i] <= cell_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result assembly, taken from the cells before the shift.
  always_comb begin
    rsp_nxt = '0;
    rsp_nxt.status = ST_NOTFOUND;
    rsp_nxt.entry_count_out = CountW'(count_nxt);
    unique case (op_sel)
      OP_INSERT: begin
        if (dup_r) begin
          rsp_nxt.status = ST_DUP;
          rsp_nxt.found_position = PosW'(dup_idx_r);
          rsp_nxt.out_id = cell_r[dup_idx_r].id;
          rsp_nxt.out_first_name_ref = cell_r[dup_idx_r].first;
          rsp_nxt.out_last_name_ref = cell_r[dup_idx_r].last;
          rsp_nxt.out_major_ref = cell_r[dup_idx_r].major;
          rsp_nxt.out_gpa_hundredths = cell_r[dup_idx_r].grade;
        end else if (count_r >= IW'(DEPTH)) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          rsp_nxt.status = ST_OK;
          rsp_nxt.found_position = PosW'(ins_pos_r);
          rsp_nxt.out_id = new_rec.id;
          rsp_nxt.out_first_name_ref = new_rec.first;
          rsp_nxt.out_last_name_ref = new_rec.last;
          rsp_nxt.out_major_ref = new_rec.major;
          rsp_nxt.out_gpa_hundredths = new_rec.grade;
        end
      end
      OP_DELETE: begin
        if (dup_r) begin
          rsp_nxt.status = ST_OK;
          rsp_nxt.found_position = PosW'(dup_idx_r);
          rsp_nxt.out_id = cell_r[dup_idx_r].id;
          rsp_nxt.out_first_name_ref = cell_r[dup_idx_r].first;
          rsp_nxt.out_last_name_ref = cell_r[dup_idx_r].last;
          rsp_nxt.out_major_ref = cell_r[dup_idx_r].major;
          rsp_nxt.out_gpa_hundredths = cell_r[dup_idx_r].grade;
        end
      end
      OP_FIND: begin
        if (found_r) begin
          rsp_nxt.status = ST_OK;
          rsp_nxt.found_position = PosW'(find_idx_r);
          rsp_nxt.out_id = cell_r[find_idx_r].id;
          rsp_nxt.out_first_name_ref = cell_r[find_idx_r].first;
          rsp_nxt.out_last_name_ref = cell_r[find_idx_r].last;
          rsp_nxt.out_major_ref = cell_r[find_idx_r].major;
          rsp_nxt.out_gpa_hundredths = cell_r[find_idx_r].grade;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) rsp_r <= rsp_nxt;
  end

  assign rsp = rsp_r;

  // The count never exceeds the table depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= IW'(DEPTH))
    else $error("entry count beyond depth");
  // A delete never runs on an empty table.
  assert property (@(posedge clk) disable iff (!rst_n) do_del |-> count_r != '0)
    else $error("delete on empty table");
  // An insert only moves the count up by one.
  assert property (@(posedge clk) disable iff (!rst_n) do_ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert count step wrong");

endmodule

// ===== src/sukt_ctrl.sv =====
module sukt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          op_sel,
  output logic                busy,
  output logic                out_valid,
  output sukt_pkg::sukt_cmd_t cmd
);
  import sukt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       valid_r;

  // Idle, then the compare state, then update and respond.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_nxt = S_CMP;
      end
      S_CMP: state_nxt = S_UPD;
      S_UPD: begin
        cmd.shift_in  = (op_sel == OP_INSERT);
        cmd.shift_out = (op_sel == OP_DELETE);
        cmd.respond   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.respond;
    end
  end

  // A result strobe follows the update cycle exactly.
  assert property (@(posedge clk) disable iff (!rst_n) state_r == S_UPD |=> out_valid)
    else $error("missing result strobe");
  // A start while busy never loads.
  assert property (@(posedge clk) disable iff (!rst_n) busy |-> !cmd.load)
    else $error("load while busy");
  // The strobe lasts one cycle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("strobe longer than one cycle");

endmodule

// ===== src/sorted_unique_key_table.sv =====
// Channel   Direction  Handshake          Payload
// request   in         start, busy        in_req  (sukt_req_t)
// result    out        out_valid strobe   out_rsp (sukt_rsp_t)
//
// All cells are compared in the cycle a request is accepted and the hits are
// registered at that edge; the next cycle encodes them, and the cycle after
// shifts the cells and registers the result. The strobe comes from a register
// loaded together with the result. busy is high while the hits are encoded and
// the cells shift, so a new request is taken no earlier than the cycle in which
// the strobe of the one before is shown. Synchronous active-low reset empties the table.
// The receiver cannot stall: the result is shown for one cycle only.
module sorted_unique_key_table #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sukt_pkg::sukt_req_t in_req,
  output logic                out_valid,
  output sukt_pkg::sukt_rsp_t out_rsp
);
  import sukt_pkg::*;

  localparam int IW = $clog2(DEPTH + 1);

  sukt_cmd_t  cmd;
  logic [1:0] op_sel;

  sukt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op_sel(op_sel), .busy(busy),
    .out_valid(out_valid), .cmd(cmd)
  );

  sukt_datapath #(.DEPTH(DEPTH), .IW(IW)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_req), .cmd(cmd),
    .op_sel(op_sel), .rsp(out_rsp)
  );

endmodule
